### design/mfq_pkg.sv
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared codes, reset values and beat types of the mains failure qualifier.
// ----------------------------------------------------------------------------
package mfq_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int DELAY_WIDTH     = 16;
	localparam int CFG_IDX_WIDTH   = 2;

	localparam logic [1:0] ACT_TICK      = 2'd0;
	localparam logic [1:0] ACT_CONSIST   = 2'd1;
	localparam logic [1:0] ACT_CONTACTOR = 2'd2;
	localparam logic [1:0] ACT_MAINSFAIL = 2'd3;

	localparam logic [1:0] REQ_NORMAL = 2'd0;
	localparam logic [1:0] REQ_NEW    = 2'd1;
	localparam logic [1:0] REQ_KILL   = 2'd2;

	localparam logic [1:0] RES_PROCESSING = 2'd0;
	localparam logic [1:0] RES_OK         = 2'd1;
	localparam logic [1:0] RES_FAIL       = 2'd2;
	localparam logic [1:0] RES_TICK       = 2'd3;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_RESTORE   = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_CONTACTOR = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MAINSFAIL = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_BATT_EN   = 2'd3;

	localparam logic [DELAY_WIDTH-1:0] RESTORE_DELAY_RST   = 16'd10;
	localparam logic [DELAY_WIDTH-1:0] CONTACTOR_DELAY_RST = 16'd2;
	localparam logic [DELAY_WIDTH-1:0] MAINSFAIL_DELAY_RST = 16'd5;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] task_req;
		logic       mains_failed;
		logic       gen_contact_closed;
		logic       mains_contact_closed;
		logic       engine_cranking;
		logic       engine_stopping;
		logic       battery_low;
	} item_t;

	typedef struct packed {
		logic [1:0] result;
		logic       clear_crank_timer;
		logic       mains_healthy;
		logic       mains_fail_timed_out;
	} res_t;

	typedef struct packed {
		logic restore_running;
		logic contact_running;
		logic fail_running;
		logic healthy;
		logic timed_out;
		logic gen_settle_done;
		logic mains_settle_done;
	} flags_t;

	typedef struct packed {
		logic [DELAY_WIDTH-1:0] restore_delay;
		logic [DELAY_WIDTH-1:0] contactor_delay;
		logic [DELAY_WIDTH-1:0] mainsfail_delay;
		logic                   battery_monitor_enable;
	} cfg_t;

endpackage

### design/mfq_step.sv
// ----------------------------------------------------------------------------
// mfq_step
// Next-state and result logic for one item: tick or one of the three checks.
// ----------------------------------------------------------------------------
module mfq_step
	import mfq_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  item_t                  item,
	input  cfg_t                   cfg,
	input  flags_t                 flags,
	input  logic [TIMER_WIDTH-1:0] restore_timer,
	input  logic [TIMER_WIDTH-1:0] contact_timer,
	input  logic [TIMER_WIDTH-1:0] fail_timer,
	output flags_t                 flags_nxt,
	output logic [TIMER_WIDTH-1:0] restore_timer_nxt,
	output logic [TIMER_WIDTH-1:0] contact_timer_nxt,
	output logic [TIMER_WIDTH-1:0] fail_timer_nxt,
	output res_t                   res
);

	function automatic logic [TIMER_WIDTH-1:0] count_down(input logic [TIMER_WIDTH-1:0] t);
		count_down = (t != '0) ? t - TIMER_WIDTH'(1) : '0;
	endfunction

	logic opened;
	logic kill;

	assign kill   = (item.task_req == REQ_KILL);
	assign opened = (!item.gen_contact_closed && !flags.gen_settle_done) ||
	                (!item.mains_contact_closed && !flags.mains_settle_done);

	always_comb begin
		flags_nxt             = flags;
		restore_timer_nxt     = restore_timer;
		contact_timer_nxt     = contact_timer;
		fail_timer_nxt        = fail_timer;
		res.result            = RES_TICK;
		res.clear_crank_timer = 1'b0;

		case (item.action)
			ACT_TICK: begin
				restore_timer_nxt = count_down(restore_timer);
				contact_timer_nxt = count_down(contact_timer);
				fail_timer_nxt    = count_down(fail_timer);
				res.result        = RES_TICK;
			end
			ACT_CONSIST: begin
				if (!flags.healthy && !flags.restore_running) begin
					restore_timer_nxt         = TIMER_WIDTH'(cfg.restore_delay);
					flags_nxt.restore_running = 1'b1;
				end else if (kill) begin
					restore_timer_nxt = '0;
				end
				if (restore_timer_nxt != '0) begin
					if (item.mains_failed) begin
						flags_nxt.restore_running = 1'b0;
						flags_nxt.healthy         = 1'b0;
						res.result                = RES_FAIL;
					end else begin
						res.result = RES_PROCESSING;
					end
				end else begin
					flags_nxt.restore_running = 1'b0;
					if (!item.mains_failed) begin
						flags_nxt.healthy   = 1'b1;
						flags_nxt.timed_out = 1'b0;
						res.result          = RES_OK;
					end else begin
						flags_nxt.healthy = 1'b0;
						res.result        = RES_FAIL;
					end
				end
			end
			ACT_CONTACTOR: begin
				if ((opened && !flags.contact_running) || item.task_req == REQ_NEW) begin
					flags_nxt.contact_running = 1'b1;
					contact_timer_nxt         = TIMER_WIDTH'(cfg.contactor_delay);
					res.clear_crank_timer     = !item.engine_cranking && !item.engine_stopping;
				end else if (kill) begin
					contact_timer_nxt = '0;
				end
				if (item.gen_contact_closed)
					flags_nxt.gen_settle_done = 1'b0;
				if (item.mains_contact_closed)
					flags_nxt.mains_settle_done = 1'b0;
				if (contact_timer_nxt != '0) begin
					res.result = RES_PROCESSING;
				end else begin
					res.result = RES_OK;
					if (flags_nxt.contact_running) begin
						flags_nxt.contact_running = 1'b0;
						if (!item.mains_contact_closed)
							flags_nxt.mains_settle_done = 1'b1;
						if (!item.gen_contact_closed)
							flags_nxt.gen_settle_done = 1'b1;
					end
				end
			end
			default: begin
				if (!flags.timed_out && !flags.healthy && !flags.fail_running) begin
					fail_timer_nxt         = TIMER_WIDTH'(cfg.mainsfail_delay);
					flags_nxt.fail_running = 1'b1;
				end else if (kill) begin
					fail_timer_nxt = '0;
				end
				if (fail_timer_nxt != '0) begin
					if (!item.mains_failed) begin
						if (flags.healthy) begin
							flags_nxt.fail_running = 1'b0;
							res.result             = RES_FAIL;
						end else begin
							res.result = RES_PROCESSING;
						end
					end else if (cfg.battery_monitor_enable && item.battery_low) begin
						flags_nxt.fail_running = 1'b0;
						flags_nxt.timed_out    = 1'b1;
						res.result             = RES_OK;
					end else begin
						res.result = RES_PROCESSING;
					end
				end else begin
					flags_nxt.fail_running = 1'b0;
					if (flags.healthy) begin
						res.result = RES_FAIL;
					end else begin
						flags_nxt.timed_out = 1'b1;
						res.result          = RES_OK;
					end
				end
			end
		endcase

		res.mains_healthy        = flags_nxt.healthy;
		res.mains_fail_timed_out = flags_nxt.timed_out;
	end

endmodule

### design/mains_failure_qualifier_core.sv
// ----------------------------------------------------------------------------
// mains_failure_qualifier_core
// Mains/generator changeover qualifier: timers, settle flags and check results.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with one item per beat (tick or check).
// Output channel: out_valid/out_stall with exactly one result beat per item.
// Configuration: cfg_valid/cfg_ready write of cfg_index/cfg_data; always
// ready, meant to be written while no item is in flight.
// Path: an accepted item is captured in the input register, evaluated against
// the timer/flag state and written into the output register once the output side
// can take it; the result shows from then on.
// Throughput: one item per cycle while the output is not stalled, set by the single
// evaluation stage between the input register and the output register.
// A stalled output holds its beat; the input register keeps filling, and
// in_stall rises only while both registers hold beats and out_stall is high.
// Reset clears all timers and flags, empties both registers and loads the
// configuration defaults (restore 10, contactor 2, mains fail 5, battery
// monitoring off).
// ----------------------------------------------------------------------------
module mains_failure_qualifier_core
	import mfq_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               action,
	input  logic [1:0]               task_req,
	input  logic                     mains_failed,
	input  logic                     gen_contact_closed,
	input  logic                     mains_contact_closed,
	input  logic                     engine_cranking,
	input  logic                     engine_stopping,
	input  logic                     battery_low,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               result,
	output logic                     clear_crank_timer,
	output logic                     mains_healthy,
	output logic                     mains_fail_timed_out,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [DELAY_WIDTH-1:0]   cfg_data
);

	cfg_t                   cfg_q;
	flags_t                 flags_q;
	flags_t                 flags_nxt;
	logic [TIMER_WIDTH-1:0] restore_timer_q;
	logic [TIMER_WIDTH-1:0] contact_timer_q;
	logic [TIMER_WIDTH-1:0] fail_timer_q;
	logic [TIMER_WIDTH-1:0] restore_timer_nxt;
	logic [TIMER_WIDTH-1:0] contact_timer_nxt;
	logic [TIMER_WIDTH-1:0] fail_timer_nxt;
	item_t                  item_s1;
	logic                   valid_s1;
	res_t                   res_nxt;
	res_t                   res_q;
	logic                   out_valid_q;
	logic                   advance;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.restore_delay          <= RESTORE_DELAY_RST;
			cfg_q.contactor_delay        <= CONTACTOR_DELAY_RST;
			cfg_q.mainsfail_delay        <= MAINSFAIL_DELAY_RST;
			cfg_q.battery_monitor_enable <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RESTORE:   cfg_q.restore_delay          <= cfg_data;
				REG_CONTACTOR: cfg_q.contactor_delay        <= cfg_data;
				REG_MAINSFAIL: cfg_q.mainsfail_delay        <= cfg_data;
				REG_BATT_EN:   cfg_q.battery_monitor_enable <= cfg_data[0];
				default:       cfg_q                        <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= '{action, task_req, mains_failed, gen_contact_closed,
			             mains_contact_closed, engine_cranking, engine_stopping,
			             battery_low};
		end
	end

	mfq_step #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_step (
		.item              (item_s1),
		.cfg               (cfg_q),
		.flags             (flags_q),
		.restore_timer     (restore_timer_q),
		.contact_timer     (contact_timer_q),
		.fail_timer        (fail_timer_q),
		.flags_nxt         (flags_nxt),
		.restore_timer_nxt (restore_timer_nxt),
		.contact_timer_nxt (contact_timer_nxt),
		.fail_timer_nxt    (fail_timer_nxt),
		.res               (res_nxt)
	);

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q         <= '0;
			restore_timer_q <= '0;
			contact_timer_q <= '0;
			fail_timer_q    <= '0;
			out_valid_q     <= 1'b0;
		end else if (advance) begin
			flags_q         <= flags_nxt;
			restore_timer_q <= restore_timer_nxt;
			contact_timer_q <= contact_timer_nxt;
			fail_timer_q    <= fail_timer_nxt;
			out_valid_q     <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid            = out_valid_q;
	assign result               = res_q.result;
	assign clear_crank_timer    = res_q.clear_crank_timer;
	assign mains_healthy        = res_q.mains_healthy;
	assign mains_fail_timed_out = res_q.mains_fail_timed_out;

endmodule

### design/mfq_checker.sv
// ----------------------------------------------------------------------------
// mfq_checker
// Port-level checks of the mains failure qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module mfq_checker
	import mfq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] result,
	input logic       clear_crank_timer,
	input logic       mains_healthy,
	input logic       mains_fail_timed_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
		$stable({result, clear_crank_timer, mains_healthy, mains_fail_timed_out}))
		else $error("stalled result beat changed or dropped");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side can move");

	a_drop_only_when_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> !$past(out_stall))
		else $error("result beat vanished without being taken");

	a_clear_crank_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clear_crank_timer |-> result == RES_PROCESSING || result == RES_OK)
		else $error("crank clear with a tick or fail result");

endmodule

bind mains_failure_qualifier_core mfq_checker u_mfq_checker (.*);

### sim/tb_mains_failure_qualifier_core.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb_mains_failure_qualifier_core
// Self-checking bench for the mains failure qualifier. A directed sequence
// walks the restore, contactor settle and mains-fail paths, then random
// beats with sticky mains and contactor states run under several delay
// settings: zero, maximum, small random values and a phase with no idling.
// Each accepted beat is run through a cycle-free copy of the qualifier's
// timers and flags, and every result beat is compared field by field, in
// order, against the prediction.
// ----------------------------------------------------------------------------
module tb_mains_failure_qualifier_core;
	import mfq_pkg::*;

	localparam int TW             = TIMER_WIDTH_DEF;
	localparam int IDLE_PCT       = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SHOWN      = 10;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               action;
	logic [1:0]               task_req;
	logic                     mains_failed;
	logic                     gen_contact_closed;
	logic                     mains_contact_closed;
	logic                     engine_cranking;
	logic                     engine_stopping;
	logic                     battery_low;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               result;
	logic                     clear_crank_timer;
	logic                     mains_healthy;
	logic                     mains_fail_timed_out;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [DELAY_WIDTH-1:0]   cfg_data;

	// qualifier state as predicted
	logic [DELAY_WIDTH-1:0] restore_dly;
	logic [DELAY_WIDTH-1:0] contact_dly;
	logic [DELAY_WIDTH-1:0] fail_dly;
	logic                   batt_en;
	logic [TW-1:0]          restore_tmr;
	logic [TW-1:0]          contact_tmr;
	logic [TW-1:0]          fail_tmr;
	logic                   restore_run;
	logic                   contact_run;
	logic                   fail_run;
	logic                   healthy;
	logic                   timed_out;
	logic                   gen_settled;
	logic                   mains_settled;

	res_t pending_results[$];

	int  errors;
	int  mismatches;
	int  results_checked;
	int  items_sent;
	int  settings_used;
	int  action_count[4];
	int  idle_cycles;
	bit  steady;
	bit  mains_bad;
	bit  gen_closed_s;
	bit  mains_closed_s;

	mains_failure_qualifier_core #(
		.TIMER_WIDTH(TW)
	) DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.action              (action),
		.task_req            (task_req),
		.mains_failed        (mains_failed),
		.gen_contact_closed  (gen_contact_closed),
		.mains_contact_closed(mains_contact_closed),
		.engine_cranking     (engine_cranking),
		.engine_stopping     (engine_stopping),
		.battery_low         (battery_low),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.result              (result),
		.clear_crank_timer   (clear_crank_timer),
		.mains_healthy       (mains_healthy),
		.mains_fail_timed_out(mains_fail_timed_out),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic res_t qualify_item(input item_t it);
		res_t r;
		logic opened;
		r = '0;
		case (it.action)
			ACT_TICK: begin
				if (restore_tmr != 0) restore_tmr--;
				if (contact_tmr != 0) contact_tmr--;
				if (fail_tmr != 0) fail_tmr--;
				r.result = RES_TICK;
			end
			ACT_CONSIST: begin
				if (!healthy && !restore_run) begin
					restore_tmr = TW'(restore_dly);
					restore_run = 1'b1;
				end else if (it.task_req == REQ_KILL) begin
					restore_tmr = '0;
				end
				if (restore_tmr != 0) begin
					if (it.mains_failed) begin
						restore_run = 1'b0;
						healthy     = 1'b0;
						r.result    = RES_FAIL;
					end else begin
						r.result = RES_PROCESSING;
					end
				end else begin
					restore_run = 1'b0;
					if (!it.mains_failed) begin
						healthy   = 1'b1;
						timed_out = 1'b0;
						r.result  = RES_OK;
					end else begin
						healthy  = 1'b0;
						r.result = RES_FAIL;
					end
				end
			end
			ACT_CONTACTOR: begin
				opened = (!it.gen_contact_closed && !gen_settled) ||
					(!it.mains_contact_closed && !mains_settled);
				if ((opened && !contact_run) || it.task_req == REQ_NEW) begin
					contact_run = 1'b1;
					contact_tmr = TW'(contact_dly);
					if (!it.engine_cranking && !it.engine_stopping) r.clear_crank_timer = 1'b1;
				end else if (it.task_req == REQ_KILL) begin
					contact_tmr = '0;
				end
				if (it.gen_contact_closed) gen_settled = 1'b0;
				if (it.mains_contact_closed) mains_settled = 1'b0;
				if (contact_tmr != 0) begin
					r.result = RES_PROCESSING;
				end else begin
					if (contact_run) begin
						contact_run = 1'b0;
						if (!it.mains_contact_closed) mains_settled = 1'b1;
						if (!it.gen_contact_closed) gen_settled = 1'b1;
					end
					r.result = RES_OK;
				end
			end
			default: begin
				if (!timed_out && !healthy && !fail_run) begin
					fail_tmr = TW'(fail_dly);
					fail_run = 1'b1;
				end else if (it.task_req == REQ_KILL) begin
					fail_tmr = '0;
				end
				if (fail_tmr != 0) begin
					if (!it.mains_failed) begin
						if (healthy) begin
							fail_run = 1'b0;
							r.result = RES_FAIL;
						end else begin
							r.result = RES_PROCESSING;
						end
					end else if (batt_en && it.battery_low) begin
						fail_run  = 1'b0;
						timed_out = 1'b1;
						r.result  = RES_OK;
					end else begin
						r.result = RES_PROCESSING;
					end
				end else begin
					fail_run = 1'b0;
					if (healthy) begin
						r.result = RES_FAIL;
					end else begin
						timed_out = 1'b1;
						r.result  = RES_OK;
					end
				end
			end
		endcase
		r.mains_healthy        = healthy;
		r.mains_fail_timed_out = timed_out;
		return r;
	endfunction

	always @(posedge clk) begin
		res_t  got;
		res_t  want;
		item_t it;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {result, clear_crank_timer, mains_healthy, mains_fail_timed_out};
				results_checked++;
				if (pending_results.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected result beat: result %0d clear %0b healthy %0b timed out %0b",
							got.result, got.clear_crank_timer, got.mains_healthy,
							got.mains_fail_timed_out);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						errors++;
						mismatches++;
						if (mismatches <= MAX_SHOWN) begin
							$write("mismatch at beat %0d (expected/actual): result %0d/%0d ",
								results_checked, want.result, got.result);
							$display("clear %0b/%0b healthy %0b/%0b timed out %0b/%0b",
								want.clear_crank_timer, got.clear_crank_timer,
								want.mains_healthy, got.mains_healthy,
								want.mains_fail_timed_out, got.mains_fail_timed_out);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				it = {action, task_req, mains_failed, gen_contact_closed, mains_contact_closed,
					engine_cranking, engine_stopping, battery_low};
				pending_results.push_back(qualify_item(it));
				items_sent++;
				action_count[action]++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RESTORE:   restore_dly = cfg_data;
					REG_CONTACTOR: contact_dly = cfg_data;
					REG_MAINSFAIL: fail_dly    = cfg_data;
					REG_BATT_EN:   batt_en     = cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_mains_failure_qualifier_core failed");
			$finish;
		end
	end

	function automatic item_t mk(input logic [1:0] act, input logic [1:0] tsk,
		input logic [5:0] sense);
		return {act, tsk, sense};
	endfunction

	task automatic send_item(input item_t it);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		{action, task_req, mains_failed, gen_contact_closed, mains_contact_closed,
			engine_cranking, engine_stopping, battery_low} <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
		input logic [DELAY_WIDTH-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [DELAY_WIDTH-1:0] restore,
		input logic [DELAY_WIDTH-1:0] contactor, input logic [DELAY_WIDTH-1:0] mainsfail,
		input logic batt);
		drain();
		write_reg(REG_RESTORE, restore);
		write_reg(REG_CONTACTOR, contactor);
		write_reg(REG_MAINSFAIL, mainsfail);
		write_reg(REG_BATT_EN, DELAY_WIDTH'(batt));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_random(input int n);
		item_t it;
		int    pick;
		repeat (n) begin
			if ($urandom_range(0, 99) < 6) mains_bad = !mains_bad;
			if ($urandom_range(0, 99) < 8) gen_closed_s = !gen_closed_s;
			if ($urandom_range(0, 99) < 8) mains_closed_s = !mains_closed_s;
			pick = $urandom_range(0, 99);
			it.action = (pick < 35) ? ACT_TICK : (pick < 58) ? ACT_CONSIST :
				(pick < 80) ? ACT_CONTACTOR : ACT_MAINSFAIL;
			pick = $urandom_range(0, 99);
			it.task_req = (pick < 70) ? REQ_NORMAL : (pick < 82) ? REQ_NEW :
				(pick < 95) ? REQ_KILL : REQ_UNUSED;
			// flip the sensed mains state now and then as noise
			it.mains_failed         = ($urandom_range(0, 99) < 8) ? !mains_bad : mains_bad;
			it.gen_contact_closed   = gen_closed_s;
			it.mains_contact_closed = mains_closed_s;
			it.engine_cranking      = ($urandom_range(0, 3) == 0);
			it.engine_stopping      = ($urandom_range(0, 3) == 0);
			it.battery_low          = 1'($urandom_range(0, 1));
			send_item(it);
		end
	endtask

	task automatic test_directed();
		send_item(mk(ACT_TICK, REQ_UNUSED, 6'b111111));
		send_item(mk(ACT_CONSIST, REQ_NORMAL, 6'b011000));
		send_item(mk(ACT_CONSIST, REQ_KILL, 6'b011000));
		send_item(mk(ACT_MAINSFAIL, REQ_NORMAL, 6'b111001));
		send_item(mk(ACT_CONSIST, REQ_NEW, 6'b100000));
		send_item(mk(ACT_CONSIST, REQ_KILL, 6'b000000));
		send_item(mk(ACT_CONSIST, REQ_NORMAL, 6'b100000));
		send_item(mk(ACT_MAINSFAIL, REQ_KILL, 6'b100001));
		send_item(mk(ACT_MAINSFAIL, REQ_NORMAL, 6'b000000));
		repeat (5) send_item(mk(ACT_TICK, REQ_NORMAL, 6'b000000));
		send_item(mk(ACT_MAINSFAIL, REQ_NEW, 6'b100000));
		send_item(mk(ACT_CONTACTOR, REQ_NORMAL, 6'b000000));
		send_item(mk(ACT_CONTACTOR, REQ_NEW, 6'b000110));
		send_item(mk(ACT_CONTACTOR, REQ_KILL, 6'b000000));
		send_item(mk(ACT_CONTACTOR, REQ_UNUSED, 6'b000000));
		send_item(mk(ACT_CONTACTOR, REQ_NORMAL, 6'b011000));
		send_item(mk(ACT_CONTACTOR, REQ_NORMAL, 6'b001001));
		repeat (2) send_item(mk(ACT_TICK, REQ_KILL, 6'b000000));
		send_item(mk(ACT_CONTACTOR, REQ_NORMAL, 6'b001010));
	endtask

	task automatic test_zero_delays();
		set_config('0, '0, '0, 1'b1);
		run_random(300);
	endtask

	task automatic test_max_delays();
		set_config('1, '1, '1, 1'b0);
		run_random(150);
	endtask

	task automatic test_random_delays();
		repeat (5) begin
			set_config(DELAY_WIDTH'($urandom_range(0, 6)),
				DELAY_WIDTH'($urandom_range(0, 6)),
				DELAY_WIDTH'($urandom_range(0, 6)),
				1'($urandom_range(0, 1)));
			run_random(250);
		end
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		set_config(16'd1, 16'd3, 16'd2, 1'b1);
		run_random(300);
		steady = 1'b0;
	endtask

	initial begin
		arst_n               <= 1'b0;
		in_valid             <= 1'b0;
		action               <= ACT_TICK;
		task_req             <= REQ_NORMAL;
		mains_failed         <= 1'b0;
		gen_contact_closed   <= 1'b0;
		mains_contact_closed <= 1'b0;
		engine_cranking      <= 1'b0;
		engine_stopping      <= 1'b0;
		battery_low          <= 1'b0;
		cfg_valid            <= 1'b0;
		cfg_index            <= REG_RESTORE;
		cfg_data             <= '0;
		restore_dly   = RESTORE_DELAY_RST;
		contact_dly   = CONTACTOR_DELAY_RST;
		fail_dly      = MAINSFAIL_DELAY_RST;
		batt_en       = 1'b0;
		restore_tmr   = '0;
		contact_tmr   = '0;
		fail_tmr      = '0;
		restore_run   = 1'b0;
		contact_run   = 1'b0;
		fail_run      = 1'b0;
		healthy       = 1'b0;
		timed_out     = 1'b0;
		gen_settled   = 1'b0;
		mains_settled = 1'b0;
		steady        = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_zero_delays();
		test_max_delays();
		test_random_delays();
		test_back_to_back();
		drain();
		errors += pending_results.size();
		$display("%0d beats sent under %0d register settings and reset defaults, %0d checked",
			items_sent, settings_used, results_checked);
		$display("ticks %0d, consistency %0d, contactor %0d, mains fail %0d, mismatches %0d",
			action_count[ACT_TICK], action_count[ACT_CONSIST], action_count[ACT_CONTACTOR],
			action_count[ACT_MAINSFAIL], mismatches);
		if (errors == 0) begin
			$display("tb_mains_failure_qualifier_core passed");
		end else begin
			$display("tb_mains_failure_qualifier_core failed");
		end
		$finish;
	end

endmodule
